/* hdl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ESAM_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("esam assertion failed");

// when the trigger holds, the consequence holds in the same cycle
`define ESAM_ASSERT_IMPLY(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
      else $error("esam assertion failed");

`endif

/* hdl/esam_pkg.sv */
package esam_pkg;

   // event kinds
   localparam logic [2:0] KIND_EXECUTED = 3'd0;
   localparam logic [2:0] KIND_SUCCESS  = 3'd1;
   localparam logic [2:0] KIND_PROGRESS = 3'd2;
   localparam logic [2:0] KIND_FAIL     = 3'd3;
   localparam logic [2:0] KIND_ERROR    = 3'd4;

   // entry status codes
   localparam logic [2:0] ST_STARTED  = 3'd0;
   localparam logic [2:0] ST_SUCCESS  = 3'd1;
   localparam logic [2:0] ST_PROGRESS = 3'd2;
   localparam logic [2:0] ST_ERROR    = 3'd3;
   localparam logic [2:0] ST_FAILED   = 3'd4;

   // node types
   localparam logic [2:0] NT_PATTERN      = 3'd0;
   localparam logic [2:0] NT_PATTERN_ELEM = 3'd1;
   localparam logic [2:0] NT_COMPETENCE   = 3'd2;
   localparam logic [2:0] NT_COMP_ELEM    = 3'd3;
   localparam logic [2:0] NT_DRIVE        = 3'd4;
   localparam logic [2:0] NT_ACTION       = 3'd5;

   // rule timeouts in ms
   localparam logic [15:0] RPT_T    = 16'd3333;
   localparam logic [15:0] T_500    = 16'd500;
   localparam logic [15:0] T_800    = 16'd800;
   localparam logic [15:0] T_2000   = 16'd2000;
   localparam logic [15:0] T_3000   = 16'd3000;
   localparam logic [15:0] T_5000   = 16'd5000;

   // stack entry as stored
   typedef struct packed {
      logic [2:0] node_type;
      logic [7:0] element_id;
   } esam_entry_type;

   // announcement candidate passed from front to back
   typedef struct packed {
      logic [2:0] node_type;
      logic [7:0] element_id;
      logic [2:0] status;
   } esam_cand_type;

   // speech rule
   typedef struct packed {
      logic [15:0] timeout;
      logic        repeat_myself;
      logic [15:0] repeat_timeout;
      logic        always_speak;
   } esam_rule_type;

   localparam esam_rule_type RULE_NONE = '{16'd0, 1'b0, 16'd0, 1'b0};

   // fixed rule rom, indexed by node type and status
   function automatic esam_rule_type speak_rule(input logic [2:0] node_type,
                                                input logic [2:0] status);
      esam_rule_type r;
      r = RULE_NONE;
      if (status == ST_ERROR && node_type <= NT_ACTION) begin
         r = '{T_5000, 1'b0, RPT_T, 1'b1};
      end else begin
         case (node_type)
            NT_PATTERN: begin
               if (status == ST_STARTED) r = '{T_500, 1'b0, RPT_T, 1'b0};
               else if (status == ST_SUCCESS) r = '{T_2000, 1'b0, RPT_T, 1'b0};
            end
            NT_COMPETENCE: begin
               if (status == ST_STARTED) r = '{T_800, 1'b0, RPT_T, 1'b0};
               else if (status == ST_SUCCESS) r = '{T_3000, 1'b0, RPT_T, 1'b0};
            end
            NT_DRIVE: begin
               if (status == ST_STARTED || status == ST_SUCCESS)
                  r = '{T_3000, 1'b0, RPT_T, 1'b1};
            end
            NT_ACTION: begin
               if (status == ST_STARTED) r = '{T_800, 1'b0, RPT_T, 1'b0};
               else if (status == ST_SUCCESS) r = '{T_500, 1'b0, RPT_T, 1'b0};
               else if (status == ST_FAILED) r = '{T_5000, 1'b0, RPT_T, 1'b1};
            end
            default: r = RULE_NONE;
         endcase
      end
      return r;
   endfunction

endpackage

/* hdl/esam_front.sv */
`include "assert_macros.svh"

module esam_front #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [2:0]            req_kind,
   input  logic [2:0]            req_node_type,
   input  logic [7:0]            req_element_id,
   output logic                  q_push,
   output esam_pkg::esam_cand_type q_data,
   input  logic                  q_full
);
   import esam_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam logic [CW-1:0] TOP_IDX   = CW'(STACK_DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(STACK_DEPTH);

   typedef enum logic [1:0] {
      FR_IDLE   = 2'b01,
      FR_LOOKUP = 2'b10
   } esam_front_state_type;

   esam_front_state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;       // pointer plus one, zero when empty
   logic [CW-1:0] depth_ff, depth_in;
   logic          push_ff, push_in;
   logic          keep_ff, keep_in;
   logic [2:0]    status_ff, status_in;
   logic [2:0]    type_ff, type_in;
   logic [7:0]    id_ff, id_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [AW-1:0] rd_addr;
   logic          mem_we;
   esam_entry_type mem [STACK_DEPTH];
   esam_entry_type rd_data_ff;

   logic [CW-1:0] push_target;
   logic [CW-1:0] cnt_m1;
   logic [CW-1:0] addr_p1;
   logic          hit;

   // stack level targets
   assign push_target = (cnt_ff >= DEPTH_CNT) ? TOP_IDX : cnt_ff;
   assign cnt_m1      = cnt_ff - CW'(1);
   assign addr_p1     = CW'(addr_ff) + CW'(1);
   assign hit = (depth_ff > CW'(addr_ff)) && (rd_data_ff.node_type == type_ff) &&
                (rd_data_ff.element_id == id_ff);

   assign req_full = (state_ff != FR_IDLE);

   // classify in idle, compare and update in lookup
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      depth_in  = depth_ff;
      push_in   = push_ff;
      keep_in   = keep_ff;
      status_in = status_ff;
      type_in   = type_ff;
      id_in     = id_ff;
      addr_in   = addr_ff;
      mem_we    = 1'b0;
      q_push    = 1'b0;
      q_data    = '0;
      case (state_ff)
         FR_IDLE: begin
            if (req_push) begin
               type_in = req_node_type;
               id_in   = req_element_id;
               keep_in = (req_kind == KIND_PROGRESS);
               case (req_kind)
                  KIND_SUCCESS:  status_in = ST_SUCCESS;
                  KIND_PROGRESS: status_in = ST_PROGRESS;
                  KIND_FAIL:     status_in = ST_FAILED;
                  KIND_ERROR:    status_in = ST_ERROR;
                  default:       status_in = ST_STARTED;
               endcase
               if (req_kind == KIND_EXECUTED) begin
                  push_in  = 1'b1;
                  addr_in  = push_target[AW-1:0];
                  state_in = FR_LOOKUP;
               end else if (req_kind inside {[KIND_SUCCESS:KIND_ERROR]} &&
                            cnt_ff != '0) begin
                  push_in  = 1'b0;
                  addr_in  = cnt_m1[AW-1:0];
                  state_in = FR_LOOKUP;
               end
            end
         end
         FR_LOOKUP: begin
            if (push_ff) begin
               q_data = '{type_ff, id_ff, ST_STARTED};
               if (hit) begin
                  cnt_in   = addr_p1;
                  state_in = FR_IDLE;
               end else if (!q_full) begin
                  q_push   = 1'b1;
                  mem_we   = 1'b1;
                  cnt_in   = addr_p1;
                  depth_in = addr_p1;
                  state_in = FR_IDLE;
               end
            end else begin
               q_data = '{rd_data_ff.node_type, rd_data_ff.element_id, status_ff};
               if (!q_full) begin
                  q_push = 1'b1;
                  cnt_in = cnt_m1;
                  if (!keep_ff) depth_in = cnt_m1;
                  state_in = FR_IDLE;
               end
            end
         end
         default: state_in = FR_IDLE;
      endcase
      rd_addr = addr_in;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         cnt_ff   <= '0;
         depth_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         depth_ff <= depth_in;
      end
   end

   // held word fields
   always_ff @(posedge clock) begin
      push_ff   <= push_in;
      keep_ff   <= keep_in;
      status_ff <= status_in;
      type_ff   <= type_in;
      id_ff     <= id_in;
      addr_ff   <= addr_in;
   end

   // stack entry memory
   always_ff @(posedge clock) begin
      if (mem_we) mem[addr_ff] <= '{type_ff, id_ff};
      rd_data_ff <= mem[rd_addr];
   end

   `ESAM_ASSERT_ALWAYS(depth_covers_pointer, clock, reset, depth_ff >= cnt_ff)
   `ESAM_ASSERT_ALWAYS(depth_in_range, clock, reset, depth_ff <= DEPTH_CNT)

endmodule

/* hdl/esam_queue.sv */
`include "assert_macros.svh"

module esam_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  esam_pkg::esam_cand_type push_data,
   input  logic                    pop,
   output logic                    empty,
   output esam_pkg::esam_cand_type pop_data
);
   import esam_pkg::*;

   esam_cand_type slot_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // pointer and fill count
   always_comb begin
      wr_in    = do_push ? ~wr_ff : wr_ff;
      rd_in    = do_pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_data;
   end

   `ESAM_ASSERT_ALWAYS(count_bounded, clock, reset, count_ff <= 2'd2)
   `ESAM_ASSERT_IMPLY(no_push_when_full, clock, reset, push, !full)

endmodule

/* hdl/esam_back.sv */
`include "assert_macros.svh"

module esam_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  esam_pkg::esam_cand_type q_data,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [2:0]              rsp_out_node_type,
   output logic [7:0]              rsp_out_element_id,
   output logic [2:0]              rsp_out_status,
   output logic [15:0]             rsp_speak_timeout,
   output logic                    rsp_repeat_myself,
   output logic [15:0]             rsp_repeat_timeout,
   output logic                    rsp_always_speak
);
   import esam_pkg::*;

   logic          valid_ff, valid_in;
   esam_cand_type cand_ff;
   esam_rule_type rule_ff;
   esam_rule_type rule;
   logic          out_free;
   logic          load;

   // rule lookup on the queue head
   assign rule     = speak_rule(q_data.node_type, q_data.status);
   assign out_free = !valid_ff || rsp_pop;
   assign q_pop    = !q_empty && out_free;
   assign load     = q_pop && (rule.timeout != 16'd0);

   always_comb begin
      valid_in = valid_ff && !rsp_pop;
      if (load) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   // output word register
   always_ff @(posedge clock) begin
      if (load) begin
         cand_ff <= q_data;
         rule_ff <= rule;
      end
   end

   assign rsp_empty          = !valid_ff;
   assign rsp_out_node_type  = cand_ff.node_type;
   assign rsp_out_element_id = cand_ff.element_id;
   assign rsp_out_status     = cand_ff.status;
   assign rsp_speak_timeout  = rule_ff.timeout;
   assign rsp_repeat_myself  = rule_ff.repeat_myself;
   assign rsp_repeat_timeout = rule_ff.repeat_timeout;
   assign rsp_always_speak   = rule_ff.always_speak;

   `ESAM_ASSERT_IMPLY(word_has_timeout, clock, reset, valid_ff, rule_ff.timeout != 16'd0)

endmodule

/* hdl/exec_stack_announce_monitor.sv */
// Plan-execution stack monitor. Node events enter on the req_ side as a
// queue push (req_push while req_full is low). Executed events push the
// stack, completion events pop it; each event that reaches a rule with a
// nonzero timeout yields one announcement word on the rsp_ side, read as a
// queue (the word is valid while rsp_empty is low, taken with rsp_pop).
// Events that are ignored or whose rule is silent yield no word.
// The front takes one event at a time and holds req_full high until it is
// done: it does a registered read of the stack entry memory, then the
// compare and write-back, so the memory read paces the events.
// Path: a taken event passes the front, the queue and the output register
// before its word shows on the rsp_ ports when the output side is free.
// A 2-word queue sits between the front and the rule lookup, and an output
// register follows, so the front keeps taking events while words wait. When
// rsp_pop stays low, the queue fills and req_full then holds the front.
// Reset (synchronous, active high) empties the stack, the queue and the
// output register; stack entries are not cleared and need no clearing pass.
module exec_stack_announce_monitor #(
   parameter int STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_kind,
   input  logic [2:0]  req_node_type,
   input  logic [7:0]  req_element_id,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_out_node_type,
   output logic [7:0]  rsp_out_element_id,
   output logic [2:0]  rsp_out_status,
   output logic [15:0] rsp_speak_timeout,
   output logic        rsp_repeat_myself,
   output logic [15:0] rsp_repeat_timeout,
   output logic        rsp_always_speak
);
   import esam_pkg::*;

   logic          fq_push;
   logic          fq_full;
   esam_cand_type fq_wdata;
   logic          bq_pop;
   logic          bq_empty;
   esam_cand_type bq_rdata;

   // stack tracking front
   esam_front #(.STACK_DEPTH(STACK_DEPTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_node_type  (req_node_type),
      .req_element_id (req_element_id),
      .q_push         (fq_push),
      .q_data         (fq_wdata),
      .q_full         (fq_full)
   );

   // candidate queue
   esam_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .full      (fq_full),
      .push_data (fq_wdata),
      .pop       (bq_pop),
      .empty     (bq_empty),
      .pop_data  (bq_rdata)
   );

   // rule lookup and output register
   esam_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_empty            (bq_empty),
      .q_data             (bq_rdata),
      .q_pop              (bq_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_out_node_type  (rsp_out_node_type),
      .rsp_out_element_id (rsp_out_element_id),
      .rsp_out_status     (rsp_out_status),
      .rsp_speak_timeout  (rsp_speak_timeout),
      .rsp_repeat_myself  (rsp_repeat_myself),
      .rsp_repeat_timeout (rsp_repeat_timeout),
      .rsp_always_speak   (rsp_always_speak)
   );

endmodule
